// ----- sv/clexp_pkg.sv -----
`timescale 1ns / 1ps

package clexp_pkg;

    // Request kinds carried in the input tuser
    typedef enum logic [2:0] {
        MODE_CHAR   = 3'd0,
        MODE_CURSOR = 3'd1,
        MODE_HOME   = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_INIT   = 3'd4
    } t_mode;

    // Three expander writes per nibble
    typedef enum logic [1:0] {
        PH_SETUP  = 2'd0,
        PH_STROBE = 2'd1,
        PH_HOLD   = 2'd2
    } t_phase;

    // One classified request, as queued between front and back
    typedef struct packed {
        logic        is_init;   // fixed twelve-nibble init sequence
        logic        rs;        // register select
        logic [7:0]  data;      // byte sent as two nibbles
        logic [16:0] extra;     // added to the hold pause of the second nibble
    } t_job;

    // Register indexes (paddr[2])
    localparam logic REG_EXPANDER_ADDR = 1'b0;
    localparam logic REG_ROW_COUNT     = 1'b1;

    localparam logic [6:0] EXPANDER_ADDR_RESET = 7'd39;
    localparam logic [2:0] ROW_COUNT_RESET     = 3'd4;

    localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
    localparam logic [7:0] BIT_ENABLE    = 8'h04;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    localparam logic [16:0] WAIT_STROBE = 17'd110;
    localparam logic [16:0] WAIT_HOLD   = 17'd500;
    localparam logic [16:0] EXTRA_HOME  = 17'd2000;
    localparam logic [16:0] EXTRA_CLEAR = 17'd100000;

    localparam logic [3:0] INIT_NIBBLES = 4'd12;

    function automatic logic [7:0] line_start(input logic [1:0] row);
        logic [7:0] v;
        case (row)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h40;
            2'd2:    v = 8'h14;
            default: v = 8'h54;
        endcase
        return v;
    endfunction

    // Init: 0x3,0x3,0x3,0x2 single nibbles, then bytes 0x28,0x01,0x06,0x0C
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2: v = 4'h3;
            4'd3, 4'd4:       v = 4'h2;
            4'd5:             v = 4'h8;
            4'd7:             v = 4'h1;
            4'd9:             v = 4'h6;
            4'd11:            v = 4'hC;
            default:          v = 4'h0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] init_extra(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:                      v = 17'd10000;
            4'd1:                      v = 17'd400;
            4'd3, 4'd5, 4'd7:          v = 17'd2000;
            4'd9:                      v = 17'd200;
            default:                   v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/clexp_front.sv -----
`timescale 1ns / 1ps

module clexp_front import clexp_pkg::*; (
    input  logic        i_s_tvalid,
    input  logic [2:0]  i_s_tuser,    // [2:0] mode
    input  logic [15:0] i_s_tdata,    // [7:0] char_code, [13:8] column, [15:14] row
    input  logic [2:0]  i_row_count,
    input  logic        i_q_full,
    output logic        o_s_tready,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0] char_code;
    logic [5:0] column;
    logic [1:0] row;
    logic [2:0] limit;
    logic [1:0] row_c;
    logic [7:0] cursor_addr;
    logic       known;

    assign char_code = i_s_tdata[7:0];
    assign column    = i_s_tdata[13:8];
    assign row       = i_s_tdata[15:14];

    // zero rows behaves as one row
    assign limit = (i_row_count == 3'd0) ? 3'd0 : i_row_count - 3'd1;
    assign row_c = ({1'b0, row} > limit) ? limit[1:0] : row;
    assign cursor_addr = CMD_SET_DDRAM | ({2'b00, column} + line_start(row_c));

    always_comb begin
        known   = 1'b1;
        o_job   = '0;
        unique case (t_mode'(i_s_tuser))
            MODE_CHAR: begin
                o_job.rs   = 1'b1;
                o_job.data = char_code;
            end
            MODE_CURSOR: begin
                o_job.data = cursor_addr;
            end
            MODE_HOME: begin
                o_job.data  = CMD_HOME;
                o_job.extra = EXTRA_HOME;
            end
            MODE_CLEAR: begin
                o_job.data  = CMD_CLEAR;
                o_job.extra = EXTRA_CLEAR;
            end
            MODE_INIT: begin
                o_job.is_init = 1'b1;
            end
            default: begin
                known = 1'b0;   // unused modes are swallowed
            end
        endcase
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full && known;

endmodule

// ----- sv/clexp_queue.sv -----
`timescale 1ns / 1ps

module clexp_queue import clexp_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (!do_push && do_pop) r_count <= r_count - CW'(1);
        end
    end

endmodule

// ----- sv/clexp_back.sv -----
`timescale 1ns / 1ps

module clexp_back import clexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    input  logic [6:0]  i_expander_address,
    input  logic        i_m_tready,
    output logic        o_pop,
    output logic        o_m_tvalid,
    output logic [39:0] o_m_tdata,   // [7:0] address_byte, [15:8] expander_byte,
                                     // [32:16] wait_us, [39:33] zero
    output logic        o_m_tlast
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_nib, n_nib;
    logic        r_m_tvalid;
    logic [7:0]  r_addr;
    logic [7:0]  r_exp;
    logic [16:0] r_wait;
    logic        r_last;

    logic        adv;
    logic        nib_last;
    logic [3:0]  nibble;
    logic [16:0] extra;
    logic [7:0]  base;
    logic [7:0]  exp_byte;
    logic [16:0] wait_us;

    assign adv      = i_job_valid && (!r_m_tvalid || i_m_tready);
    assign nib_last = i_job.is_init ? (r_nib == INIT_NIBBLES - 4'd1) : r_nib[0];
    assign nibble   = i_job.is_init ? init_nibble(r_nib)
                    : (r_nib[0] ? i_job.data[3:0] : i_job.data[7:4]);
    assign extra    = i_job.is_init ? init_extra(r_nib)
                    : (r_nib[0] ? i_job.extra : 17'd0);
    assign base     = {nibble, 4'b0000} | BIT_BACKLIGHT | {7'b0, i_job.rs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SETUP;
            r_nib   <= '0;
        end else begin
            r_phase <= n_phase;
            r_nib   <= n_nib;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_nib    = r_nib;
        o_pop    = 1'b0;
        exp_byte = base;
        wait_us  = 17'd0;
        unique case (r_phase)
            PH_SETUP: begin
                if (adv) n_phase = PH_STROBE;
            end
            PH_STROBE: begin
                exp_byte = base | BIT_ENABLE;
                wait_us  = WAIT_STROBE;
                if (adv) n_phase = PH_HOLD;
            end
            PH_HOLD: begin
                wait_us = WAIT_HOLD + extra;
                if (adv) begin
                    n_phase = PH_SETUP;
                    if (nib_last) begin
                        n_nib = '0;
                        o_pop = 1'b1;
                    end else begin
                        n_nib = r_nib + 4'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_SETUP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (adv) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_addr <= {i_expander_address, 1'b0};
            r_exp  <= exp_byte;
            r_wait <= wait_us;
            r_last <= (r_phase == PH_HOLD) && nib_last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {7'b0, r_wait, r_exp, r_addr};
    assign o_m_tlast  = r_last;

endmodule

// ----- sv/char_lcd_expander_sequencer_top.sv -----
`timescale 1ns / 1ps

// Character LCD sequencer for an HD44780-type display in 4-bit mode behind
// an I2C port expander. Each request (char, set cursor, home, clear, init)
// becomes a run of expander writes: every nibble gives three writes (setup,
// enable high with 110 us pause, enable low with 500 us plus the command's
// extra pause); tlast marks the final write of a request. The output puts
// out at most one write per clock; a character, cursor, home or clear
// request gives 6 writes and init gives 36; unused modes are consumed with
// no output. The back-end sequencer's single write per cycle, while the output is ready, sets that rate.
// A queue of QUEUE_DEPTH classified requests sits between the input
// classifier and the sequencer, so new requests are taken while earlier
// ones are still going out. Cursor rows clamp to row_count-1 (zero
// rows acts as one). Configuration: APB, register 0 at 0x0 expander address
// (reset 39), register 1 at 0x4 row count (reset 4); write only when idle.
module char_lcd_expander_sequencer_top import clexp_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] char_code, [13:8] column, [15:14] row
    input  logic [2:0]  i_s_tuser,   // [2:0] mode
    // expander writes out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] address_byte, [15:8] expander_byte,
                                     // [32:16] wait_us, [39:33] zero
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_expander_address;
    logic [2:0] r_row_count;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job front_job;
    t_job q_job;

    // ---- configuration registers ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expander_address <= EXPANDER_ADDR_RESET;
            r_row_count        <= ROW_COUNT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_EXPANDER_ADDR: r_expander_address <= pwdata[6:0];
                REG_ROW_COUNT:     r_row_count        <= pwdata[2:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPANDER_ADDR: prdata = {25'b0, r_expander_address};
            REG_ROW_COUNT:     prdata = {29'b0, r_row_count};
            default:           prdata = '0;
        endcase
    end

    // ---- front: accept and classify ----
    clexp_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_row_count(r_row_count),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (push),
        .o_job      (front_job)
    );

    // ---- request queue ----
    clexp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    // ---- back: nibble / write sequencer with output register ----
    clexp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (q_valid),
        .i_job             (q_job),
        .i_expander_address(r_expander_address),
        .i_m_tready        (i_m_tready),
        .o_pop             (pop),
        .o_m_tvalid        (o_m_tvalid),
        .o_m_tdata         (o_m_tdata),
        .o_m_tlast         (o_m_tlast)
    );

    // ---- assertions ----
    // the final write of a request is always an enable-low hold write
    a_last_is_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[10] && (o_m_tdata[32:16] >= 17'd500))
        else $error("last write is not a hold write");

    // enable-high writes carry the strobe pause
    a_strobe_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10] |-> (o_m_tdata[32:16] == WAIT_STROBE) && !o_m_tlast)
        else $error("strobe write with wrong pause");

    // reset leaves no write pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import clexp_pkg::*;

    // One expander write as it should leave the block
    typedef struct packed {
        logic [7:0]  addr_byte;
        logic [7:0]  lcd_byte;
        logic [16:0] pause_us;
        logic        last;
    } t_lcd_write;

    // HD44780 commands used by the power-up sequence
    localparam logic [7:0] LCD_FUNC_8BIT       = 8'h30;
    localparam logic [7:0] LCD_FUNC_4BIT_2LINE = 8'h28;
    localparam logic [7:0] LCD_ENTRY_INC       = 8'h06;
    localparam logic [7:0] LCD_SCREEN_ENABLE   = 8'h0C;

    localparam int SETTLE_CYCLES  = 40;    // quiet time before a register write
    localparam int HOLD_CYCLES    = 200;   // long output stall to back up the input
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any item moving
    localparam int PRINT_LIMIT    = 200;

    // Predicts the expander writes of each request and checks them in order
    class lcd_write_scoreboard;
        t_lcd_write  pending_writes[$];
        logic [6:0]  expander_addr;
        logic [2:0]  row_count;
        int unsigned mismatches;

        function new();
            expander_addr = EXPANDER_ADDR_RESET;
            row_count     = ROW_COUNT_RESET;
            mismatches    = 0;
        endfunction

        function void push_write(input logic [7:0] lcd_byte, input logic [16:0] pause);
            t_lcd_write w;
            w.addr_byte = {expander_addr, 1'b0};
            w.lcd_byte  = lcd_byte;
            w.pause_us  = pause;
            w.last      = 1'b0;
            pending_writes.push_back(w);
        endfunction

        // setup, enable high, enable low; the extra pause lands on the last one
        function void queue_nibble(input logic [7:0] nib, input logic rs,
                                   input logic [16:0] extra);
            logic [7:0] d;
            d = (nib & 8'hF0) | {7'd0, rs} | BIT_BACKLIGHT;
            push_write(d, 17'd0);
            push_write(d | BIT_ENABLE, WAIT_STROBE);
            push_write(d & ~BIT_ENABLE, WAIT_HOLD + extra);
        endfunction

        function void queue_byte(input logic [7:0] b, input logic rs,
                                 input logic [16:0] extra);
            queue_nibble(b & 8'hF0, rs, 17'd0);
            queue_nibble({b[3:0], 4'h0}, rs, extra);
        endfunction

        function void note_request(input logic [2:0] mode, input logic [7:0] ch,
                                   input logic [5:0] col, input logic [1:0] row);
            int         first;
            logic [2:0] top_row;
            logic [1:0] r;
            logic [7:0] line_base;
            t_lcd_write w;
            first = pending_writes.size();
            case (mode)
                MODE_CHAR: queue_byte(ch, 1'b1, 17'd0);
                MODE_CURSOR: begin
                    // zero rows behaves as one row
                    top_row = (row_count == 3'd0) ? 3'd0 : row_count - 3'd1;
                    r = row;
                    if ({1'b0, row} > top_row)
                        r = top_row[1:0];
                    case (r)
                        2'd0:    line_base = 8'h00;
                        2'd1:    line_base = 8'h40;
                        2'd2:    line_base = 8'h14;
                        default: line_base = 8'h54;
                    endcase
                    queue_byte(CMD_SET_DDRAM | 8'({2'b00, col} + line_base), 1'b0, 17'd0);
                end
                MODE_HOME:  queue_byte(CMD_HOME, 1'b0, EXTRA_HOME);
                MODE_CLEAR: queue_byte(CMD_CLEAR, 1'b0, EXTRA_CLEAR);
                MODE_INIT: begin
                    queue_nibble(LCD_FUNC_8BIT, 1'b0, 17'd10000);
                    queue_nibble(LCD_FUNC_8BIT, 1'b0, 17'd400);
                    queue_nibble(LCD_FUNC_8BIT, 1'b0, 17'd0);
                    queue_nibble(LCD_FUNC_4BIT_2LINE, 1'b0, 17'd2000);
                    queue_byte(LCD_FUNC_4BIT_2LINE, 1'b0, 17'd2000);
                    queue_byte(CMD_CLEAR, 1'b0, 17'd2000);
                    queue_byte(LCD_ENTRY_INC, 1'b0, 17'd200);
                    queue_byte(LCD_SCREEN_ENABLE, 1'b0, 17'd0);
                end
                default: ;  // unused codes are dropped
            endcase
            if (pending_writes.size() > first) begin
                w = pending_writes.pop_back();
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        endfunction

        task report(input string msg);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_write(input logic [39:0] data, input logic tlast);
            t_lcd_write w;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected write data=%h last=%b", data, tlast));
                return;
            end
            w = pending_writes.pop_front();
            if (data[7:0] != w.addr_byte)
                report($sformatf("address byte %h, want %h", data[7:0], w.addr_byte));
            if (data[15:8] != w.lcd_byte)
                report($sformatf("expander byte %h, want %h", data[15:8], w.lcd_byte));
            if (data[32:16] != w.pause_us)
                report($sformatf("wait %0d us, want %0d", data[32:16], w.pause_us));
            if (data[39:33] != 7'd0)
                report($sformatf("padding bits %h not zero", data[39:33]));
            if (tlast != w.last)
                report($sformatf("tlast %b, want %b", tlast, w.last));
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = 16'd0;   // [7:0] char_code, [13:8] column, [15:14] row
    logic [2:0]  i_s_tuser  = 3'd0;    // [2:0] mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;            // [7:0] address, [15:8] expander byte, [32:16] wait
    logic        o_m_tlast;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = 3'd0;
    logic [31:0] pwdata     = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    lcd_write_scoreboard board;

    // traffic shaping knobs set by the main sequence between edges, then the stall and quiet counters
    int idle_pct    = 0;
    int stall_pct   = 0;
    bit pressure_on = 1'b0;
    int hold_count  = 0;
    int quiet_cycles = 0;

    char_lcd_expander_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: random stalls, plus one long hold-off when pressure is on
    always @(posedge i_clk) begin
        if (!pressure_on)
            hold_count = 0;
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            hold_count = hold_count + 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitors: note requests before checking writes taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                board.note_request(i_s_tuser, i_s_tdata[7:0], i_s_tdata[13:8],
                                   i_s_tdata[15:14]);
            if (o_m_tvalid && i_m_tready)
                board.check_write(o_m_tdata, o_m_tlast);
        end
    end

    // Watchdog on cycles where no item moves on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request, with random gaps before it, and wait for acceptance
    task automatic send_request(input logic [2:0] mode, input logic [7:0] ch,
                                input logic [5:0] col, input logic [1:0] row);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {row, col, ch};
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // Stop offering and let every expected write drain out; the extra edge
    // lets the monitor note a request taken at the current edge first
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_EXPANDER_ADDR)
            board.expander_addr = value[6:0];
        else
            board.row_count = value[2:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] addr, input logic [2:0] rows);
        wait_idle();
        apb_write({REG_EXPANDER_ADDR, 2'b00}, {25'd0, addr});
        apb_write({REG_ROW_COUNT, 2'b00}, {29'd0, rows});
    endtask

    // Random traffic; dropped (unused) codes ride along as noise
    task automatic run_traffic(input int count, input int idle, input int stall);
        int         sent;
        int         pick;
        logic [2:0] mode;
        sent      = 0;
        idle_pct  = idle;
        stall_pct = stall;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 40)      mode = MODE_CHAR;
            else if (pick < 65) mode = MODE_CURSOR;
            else if (pick < 73) mode = MODE_HOME;
            else if (pick < 81) mode = MODE_CLEAR;
            else if (pick < 86) mode = MODE_INIT;
            else                mode = 3'($urandom_range(7, 5));
            send_request(mode, 8'($urandom_range(255)), 6'($urandom_range(63)),
                         2'($urandom_range(3)));
            if (mode <= MODE_INIT)
                sent++;
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every request kind, field extremes
        send_request(MODE_CHAR, 8'h00, 6'd0, 2'd0);
        send_request(MODE_CHAR, 8'hFF, 6'd63, 2'd3);
        send_request(MODE_CHAR, 8'h5A, 6'd21, 2'd1);
        send_request(MODE_CURSOR, 8'h00, 6'd0, 2'd0);
        send_request(MODE_CURSOR, 8'hFF, 6'd63, 2'd3);   // top of the address range
        send_request(MODE_CURSOR, 8'h00, 6'd21, 2'd2);
        send_request(MODE_CURSOR, 8'h00, 6'd40, 2'd1);
        send_request(MODE_HOME, 8'h00, 6'd0, 2'd0);
        send_request(MODE_CLEAR, 8'h00, 6'd0, 2'd0);
        send_request(MODE_INIT, 8'h00, 6'd0, 2'd0);
        send_request(3'd5, 8'hAA, 6'd10, 2'd1);          // unused codes: no writes
        send_request(3'd6, 8'h55, 6'd20, 2'd2);
        send_request(3'd7, 8'hFF, 6'd63, 2'd3);
        send_request(MODE_CHAR, 8'h41, 6'd0, 2'd0);

        // Row clamping at two rows
        configure(7'd39, 3'd2);
        send_request(MODE_CURSOR, 8'h00, 6'd5, 2'd3);
        send_request(MODE_CURSOR, 8'h00, 6'd5, 2'd2);
        // zero rows acts as one row
        configure(7'd39, 3'd0);
        send_request(MODE_CURSOR, 8'h00, 6'd7, 2'd3);
        send_request(MODE_CURSOR, 8'h00, 6'd7, 2'd1);
        // more rows than the row field can reach: no clamp
        configure(7'd127, 3'd7);
        send_request(MODE_CURSOR, 8'h00, 6'd63, 2'd3);
        // lowest address, single row
        configure(7'd0, 3'd1);
        send_request(MODE_CHAR, 8'h80, 6'd0, 2'd0);
        send_request(MODE_CURSOR, 8'h00, 6'd33, 2'd2);

        // Random phases under different settings and idling patterns
        configure(7'd127, 3'd4);
        run_traffic(100, 0, 0);
        configure(7'd0, 3'd1);
        run_traffic(90, 53, 0);
        configure(7'($urandom_range(127)), 3'd2);
        run_traffic(90, 0, 53);
        configure(7'($urandom_range(127)), 3'd3);
        run_traffic(90, 23, 23);

        // Back-pressure: output held off long enough for the input to stall
        configure(7'($urandom_range(127)), 3'd5);
        pressure_on = 1'b1;
        run_traffic(40, 0, 0);
        wait_idle();
        pressure_on = 1'b0;

        if (board.pending_writes.size() != 0)
            board.report($sformatf("%0d writes never arrived", board.pending_writes.size()));
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
